>>> design/icp_pkg.sv
// Shared types, constants and token matcher for the icon command parser.
package icp_pkg;

  localparam int unsigned WORD_MAX    = 7;
  localparam int unsigned TOK_W       = 8 * WORD_MAX;
  localparam int unsigned MASK_W      = 19;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_NL     = 8'h0A;
  localparam logic [7:0] DIGIT_ZERO  = 8'h30;
  localparam logic [7:0] DIGIT_TWO   = 8'h32;
  localparam logic [7:0] DIGIT_NINE  = 8'h39;

  localparam logic [14:0] BASE_BITS = 15'h7FFF;
  localparam logic [3:0]  VOL_ALL   = 4'd12;
  localparam logic [3:0]  VOL_TEN   = 4'd10;
  localparam logic [7:0]  UNK_MAX   = 8'hFF;

  // One closed token handed from the front end to the back end.
  typedef struct packed {
    logic             last;
    logic             nonempty;
    logic             fits;
    logic [2:0]       len;
    logic [TOK_W-1:0] tok;
  } qent_t;

  typedef struct packed {
    logic              known;
    logic              clr;
    logic              set;
    logic [MASK_W-1:0] bits;
  } match_t;

  typedef struct packed {
    logic [2:0]        len;
    logic [TOK_W-1:0]  txt;
    logic              clr;
    logic              set;
    logic [MASK_W-1:0] bits;
  } word_t;

  localparam int unsigned WORD_COUNT = 34;
  localparam logic [MASK_W-1:0] ALL_BITS = {VOL_ALL, BASE_BITS};

  // Text is right-aligned: the first character sits in the highest used byte.
  localparam word_t WORD_LIST [WORD_COUNT] = '{
    '{3'd3, TOK_W'("clk"),     1'b0, 1'b0, MASK_W'(1) << 4},
    '{3'd5, TOK_W'("clock"),   1'b0, 1'b0, MASK_W'(1) << 4},
    '{3'd3, TOK_W'("rad"),     1'b0, 1'b0, MASK_W'(1) << 3},
    '{3'd5, TOK_W'("radio"),   1'b0, 1'b0, MASK_W'(1) << 3},
    '{3'd3, TOK_W'("mus"),     1'b0, 1'b0, MASK_W'(1) << 2},
    '{3'd5, TOK_W'("music"),   1'b0, 1'b0, MASK_W'(1) << 2},
    '{3'd2, TOK_W'("cd"),      1'b0, 1'b0, MASK_W'(1) << 1},
    '{3'd3, TOK_W'("dvd"),     1'b0, 1'b0, MASK_W'(1) << 1},
    '{3'd2, TOK_W'("tv"),      1'b0, 1'b0, MASK_W'(1) << 0},
    '{3'd4, TOK_W'("tele"),    1'b0, 1'b0, MASK_W'(1) << 0},
    '{3'd3, TOK_W'("cam"),     1'b0, 1'b0, MASK_W'(1) << 9},
    '{3'd6, TOK_W'("camera"),  1'b0, 1'b0, MASK_W'(1) << 9},
    '{3'd3, TOK_W'("rew"),     1'b0, 1'b0, MASK_W'(1) << 8},
    '{3'd6, TOK_W'("rewind"),  1'b0, 1'b0, MASK_W'(1) << 8},
    '{3'd3, TOK_W'("rec"),     1'b0, 1'b0, MASK_W'(1) << 7},
    '{3'd6, TOK_W'("record"),  1'b0, 1'b0, MASK_W'(1) << 7},
    '{3'd2, TOK_W'("pl"),      1'b0, 1'b0, MASK_W'(1) << 6},
    '{3'd4, TOK_W'("play"),    1'b0, 1'b0, MASK_W'(1) << 6},
    '{3'd2, TOK_W'("pa"),      1'b0, 1'b0, MASK_W'(1) << 5},
    '{3'd5, TOK_W'("pause"),   1'b0, 1'b0, MASK_W'(1) << 5},
    '{3'd2, TOK_W'("st"),      1'b0, 1'b0, MASK_W'(1) << 14},
    '{3'd4, TOK_W'("stop"),    1'b0, 1'b0, MASK_W'(1) << 14},
    '{3'd2, TOK_W'("ff"),      1'b0, 1'b0, MASK_W'(1) << 13},
    '{3'd3, TOK_W'("rev"),     1'b0, 1'b0, MASK_W'(1) << 12},
    '{3'd7, TOK_W'("reverse"), 1'b0, 1'b0, MASK_W'(1) << 12},
    '{3'd3, TOK_W'("rep"),     1'b0, 1'b0, MASK_W'(1) << 11},
    '{3'd6, TOK_W'("repeat"),  1'b0, 1'b0, MASK_W'(1) << 11},
    '{3'd4, TOK_W'("mute"),    1'b0, 1'b0, MASK_W'(1) << 10},
    '{3'd4, TOK_W'("vol0"),    1'b0, 1'b0, MASK_W'(1) << 10},
    '{3'd3, TOK_W'("all"),     1'b0, 1'b0, ALL_BITS},
    '{3'd5, TOK_W'("world"),   1'b0, 1'b0, ALL_BITS},
    '{3'd5, TOK_W'("clear"),   1'b1, 1'b0, MASK_W'(0)},
    '{3'd4, TOK_W'("none"),    1'b1, 1'b0, MASK_W'(0)},
    '{3'd1, TOK_W'("="),       1'b0, 1'b1, MASK_W'(0)}
  };

  function automatic match_t match_word(input logic [TOK_W-1:0] tok, input logic [2:0] len);
    match_t           r;
    logic [TOK_W-1:0] msk;
    r = '0;
    for (int i = 0; i < WORD_COUNT; i++) begin
      msk = ~({TOK_W{1'b1}} << {WORD_LIST[i].len, 3'b000});
      if (len == WORD_LIST[i].len && (tok & msk) == WORD_LIST[i].txt) begin
        r.known = 1'b1;
        r.clr   = r.clr | WORD_LIST[i].clr;
        r.set   = r.set | WORD_LIST[i].set;
        r.bits  = r.bits | WORD_LIST[i].bits;
      end
    end
    if (len == 3'd4 && tok[31:8] == 24'("vol") && tok[7:0] > DIGIT_ZERO &&
        tok[7:0] <= DIGIT_NINE) begin
      r.known = 1'b1;
      r.bits  = {tok[3:0], 15'd0};
    end
    if (len == 3'd5 && tok[39:8] == 32'("vol1") && tok[7:0] >= DIGIT_ZERO &&
        tok[7:0] <= DIGIT_TWO) begin
      r.known = 1'b1;
      r.bits  = {VOL_TEN + {2'b00, tok[1:0]}, 15'd0};
    end
    return r;
  endfunction

endpackage

>>> design/icp_front.sv
// Front end: collects command bytes into tokens and pushes closed tokens.
module icp_front #(
  parameter int unsigned TOKEN_CHARS = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [7:0]         in_char,
  input  logic               in_tlast,
  output logic               push,
  output icp_pkg::qent_t     push_ent
);

  localparam int unsigned LW = $clog2(TOKEN_CHARS + 1);

  logic [LW-1:0]              len_r, len_nxt, len_a, sel_len;
  logic                       ovl_r, ovl_nxt, ovl_a, sel_ovl;
  logic                       stop_r, stop_nxt;
  logic [icp_pkg::TOK_W-1:0]  tok_r, tok_nxt, tok_a, sel_tok;
  logic                       is_delim, delim_close, accept;

  assign accept   = in_tvalid && in_tready;
  assign is_delim = in_char == icp_pkg::CHAR_COMMA || in_char == icp_pkg::CHAR_SPACE ||
                    in_char == icp_pkg::CHAR_NL;

  always_comb begin
    len_a       = len_r;
    ovl_a       = ovl_r;
    tok_a       = tok_r;
    stop_nxt    = stop_r;
    delim_close = 1'b0;
    if (!stop_r) begin
      if (in_char == icp_pkg::CHAR_NUL) begin
        stop_nxt = 1'b1;
      end else if (is_delim) begin
        delim_close = 1'b1;
        len_a       = '0;
        ovl_a       = 1'b0;
      end else if (len_r < LW'(TOKEN_CHARS)) begin
        len_a = len_r + LW'(1);
        if (len_r < LW'(icp_pkg::WORD_MAX)) begin
          tok_a = {tok_r[icp_pkg::TOK_W-9:0], in_char};
        end
      end else begin
        ovl_a = 1'b1;
      end
    end

    sel_len = delim_close ? len_r : len_a;
    sel_ovl = delim_close ? ovl_r : ovl_a;
    sel_tok = delim_close ? tok_r : tok_a;

    push_ent.last     = in_tlast;
    push_ent.nonempty = (sel_len != '0) || sel_ovl;
    push_ent.fits     = !sel_ovl && (sel_len <= LW'(icp_pkg::WORD_MAX));
    push_ent.len      = sel_len[2:0];
    push_ent.tok      = sel_tok;
    push = accept && (in_tlast || (delim_close && push_ent.nonempty));

    len_nxt = len_a;
    ovl_nxt = ovl_a;
    tok_nxt = tok_a;
    if (in_tlast) begin
      len_nxt  = '0;
      ovl_nxt  = 1'b0;
      stop_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      ovl_r  <= 1'b0;
      stop_r <= 1'b0;
    end else if (accept) begin
      len_r  <= len_nxt;
      ovl_r  <= ovl_nxt;
      stop_r <= stop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tok_r <= tok_nxt;
    end
  end

endmodule

>>> design/icp_queue.sv
// Token queue between the front end and the back end.
module icp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  icp_pkg::qent_t push_ent,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output icp_pkg::qent_t head_ent
);

  icp_pkg::qent_t                 mem_r [icp_pkg::QUEUE_DEPTH];
  logic [icp_pkg::QPTR_W-1:0]     wr_r, rd_r;
  logic [icp_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;

  assign full       = cnt_r == icp_pkg::QCNT_W'(icp_pkg::QUEUE_DEPTH);
  assign head_valid = cnt_r != '0;
  assign head_ent   = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + icp_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - icp_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= wr_r + icp_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_r <= rd_r + icp_pkg::QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_ent;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full && !pop))
    else $error("token queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && !head_valid))
    else $error("token queue underflow");

endmodule

>>> design/icp_back.sv
// Back end: matches tokens, accumulates bits and applies the mask update.
module icp_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         head_valid,
  input  icp_pkg::qent_t               head_ent,
  output logic                         pop,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [icp_pkg::MASK_W-1:0]   out_mask,
  output logic [7:0]                   out_unknown
);

  logic [icp_pkg::MASK_W-1:0] mask_r, mask_nxt;
  logic [icp_pkg::MASK_W-1:0] pend_r, pend_nxt;
  logic                       clr_r, clr_nxt, set_r, set_nxt;
  logic [7:0]                 unk_r, unk_nxt;
  logic                       oval_r;
  logic [icp_pkg::MASK_W-1:0] omask_r;
  logic [7:0]                 ounk_r;
  logic [3:0]                 vol_new;
  icp_pkg::match_t            m;
  logic                       unknown;

  assign pop = head_valid && (!head_ent.last || !oval_r || out_tready);

  always_comb begin
    m = icp_pkg::match_word(head_ent.tok, head_ent.len);
    if (!head_ent.nonempty || !head_ent.fits) begin
      m = '0;
    end
    unknown  = head_ent.nonempty && !m.known;
    pend_nxt = pend_r | m.bits;
    clr_nxt  = clr_r | m.clr;
    set_nxt  = set_r | m.set;
    unk_nxt  = (unknown && unk_r != icp_pkg::UNK_MAX) ? unk_r + 8'd1 : unk_r;

    vol_new = (mask_r[18:15] == pend_nxt[18:15]) ? 4'd0 : pend_nxt[18:15];
    priority if (clr_nxt) begin
      mask_nxt = '0;
    end else if (set_nxt) begin
      mask_nxt = pend_nxt;
    end else if (pend_nxt[18:15] != 4'd0) begin
      mask_nxt = {vol_new, mask_r[14:0] ^ pend_nxt[14:0]};
    end else begin
      mask_nxt = mask_r ^ pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      pend_r <= '0;
      clr_r  <= 1'b0;
      set_r  <= 1'b0;
      unk_r  <= '0;
      oval_r <= 1'b0;
    end else begin
      if (pop && head_ent.last) begin
        oval_r <= 1'b1;
      end else if (out_tready) begin
        oval_r <= 1'b0;
      end
      if (pop) begin
        if (head_ent.last) begin
          mask_r <= mask_nxt;
          pend_r <= '0;
          clr_r  <= 1'b0;
          set_r  <= 1'b0;
          unk_r  <= '0;
        end else begin
          pend_r <= pend_nxt;
          clr_r  <= clr_nxt;
          set_r  <= set_nxt;
          unk_r  <= unk_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_ent.last) begin
      omask_r <= mask_nxt;
      ounk_r  <= unk_nxt;
    end
  end

  assign out_tvalid  = oval_r;
  assign out_mask    = omask_r;
  assign out_unknown = ounk_r;

  a_inner_never_stalls: assert property (@(posedge clk) disable iff (!rst_n)
      head_valid && !head_ent.last |-> pop)
    else $error("non-final token held back");
  a_parse_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
      pop && head_ent.last |=> pend_r == '0 && unk_r == '0 && !clr_r && !set_r)
    else $error("parse state not cleared after command");
  a_clear_zeroes_mask: assert property (@(posedge clk) disable iff (!rst_n)
      pop && head_ent.last && clr_nxt |=> mask_r == '0 && omask_r == '0)
    else $error("clear command left icons on");

endmodule

>>> design/icon_command_parser.sv
// Icon command parser top level: front end, token queue and back end.
//
// Input channel (in_*): one command byte per request in in_tdata[7:0];
// in_tlast marks the final byte of a command. Bytes are split into tokens
// at comma, space or newline; a NUL byte ends parsing for that command.
// Output channel (out_*): one request per command, carrying the updated
// 19-bit icon mask, the four 5-bit packet data bytes and a saturating
// count of unknown tokens.
// Throughput: one byte per cycle while the queue is not full, and one result
// per cycle for back-to-back one-byte commands while the receiver is ready.
// Once the final byte is accepted its token is written into the queue, and
// the back end then pops it into the output register, raising out_tvalid.
// When the receiver stalls, the finished command waits in the output
// register; bytes keep flowing until the 4-entry token queue fills, which
// then drops in_tready.
// Reset clears the icon mask to all off, empties the queue and discards
// any partly received command.
module icon_command_parser #(
  parameter int unsigned TOKEN_CHARS = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [18:0] new_icon_mask, [23:19] volume_byte,
                                  // [28:24] group_byte_high, [33:29] group_byte_mid,
                                  // [38:34] group_byte_low, [46:39] unknown_tokens
);

  logic                        push, full, pop, head_valid;
  icp_pkg::qent_t              push_ent, head_ent;
  logic [icp_pkg::MASK_W-1:0]  mask;
  logic [7:0]                  unknown;

  assign in_tready = !full;

  icp_front #(.TOKEN_CHARS(TOKEN_CHARS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_char  (in_tdata),
    .in_tlast (in_tlast),
    .push     (push),
    .push_ent (push_ent)
  );

  icp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_ent  (push_ent),
    .full      (full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_ent  (head_ent)
  );

  icp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_ent   (head_ent),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_mask   (mask),
    .out_unknown(unknown)
  );

  assign out_tdata = {1'b0, unknown, mask[4:0], mask[9:5], mask[14:10],
                      1'b0, mask[18:15], mask};

endmodule
